[rtl/two_digit_stopwatch_display_assert.svh]
// Assertion macros used by the stopwatch display RTL.
`ifndef TWO_DIGIT_STOPWATCH_DISPLAY_ASSERT_SVH
`define TWO_DIGIT_STOPWATCH_DISPLAY_ASSERT_SVH
`ifndef SYNTHESIS
`define SWD_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define SWD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define SWD_ASSERT(lbl, clk, rst, expr)
`define SWD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/swd_pkg.sv]
// Types, constants and segment decoding for the two-digit stopwatch display.
package swd_pkg;

  typedef struct packed {
    logic start_button;
    logic pause_button;
  } in_t;

  typedef struct packed {
    logic [7:0] segments;
    logic       tens_enable;
    logic       units_enable;
    logic       green_led_n;
    logic       yellow_led_n;
    logic [6:0] count_value;
  } out_t;

  typedef enum logic [7:0] {
    CFG_DEBOUNCE_TICKS     = 8'd0,
    CFG_DIGIT_TICKS        = 8'd1,
    CFG_COUNT_PERIOD_TICKS = 8'd2,
    CFG_CATHODE_POLARITY   = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] timer;
    logic       toggle;
  } deb_t;

  localparam logic [7:0]  DEBOUNCE_RESET     = 8'd20;
  localparam logic [7:0]  DIGIT_RESET        = 8'd1;
  localparam logic [15:0] COUNT_PERIOD_RESET = 16'd1000;
  localparam logic [7:0]  BLANK_ANODE        = 8'hFF;
  localparam logic [7:0]  BLANK_CATHODE      = 8'h00;

  localparam logic [7:0] SEG_CODES [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  function automatic logic [7:0] seg_code(logic [3:0] digit, logic polarity);
    logic [3:0] idx;
    logic [7:0] code;
    idx  = (digit > 4'd9) ? 4'd0 : digit;
    code = SEG_CODES[idx];
    return polarity ? ~code : code;
  endfunction

endpackage

[rtl/two_digit_stopwatch_display.sv]
// Two-digit stopwatch with debounced buttons and a multiplexed seven-segment display.
// Each request is one 1 ms tick carrying two button levels and yields exactly one result
// with the digit drive, lamps and count after that tick. A request passes an input register
// and then a result register, which it enters when the output is not stalled; the whole tick
// update is one combinational pass between those registers, so a new request is taken every
// cycle while results are being drained. Configuration writes take effect on the next clock
// edge and belong to times when no request is in flight.
`include "two_digit_stopwatch_display_assert.svh"

module two_digit_stopwatch_display (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic [7:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  swd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output swd_pkg::out_t out_data
);

  // Configuration registers.
  logic [7:0]  debounce_ticks;
  logic [7:0]  digit_ticks;
  logic [15:0] count_period_ticks;
  logic        cathode_polarity;

  // Stopwatch state.
  logic            running, running_next;
  logic            paused, paused_next;
  logic [3:0]      tens_digit, tens_digit_next;
  logic [3:0]      units_digit, units_digit_next;
  logic [15:0]     period_timer, period_timer_next;
  logic [7:0]      digit_timer, digit_timer_next;
  logic            digit_select, digit_select_next;
  logic [7:0]      start_wait_timer, start_wait_timer_next;
  swd_pkg::phase_t start_phase, start_phase_next;
  logic [7:0]      pause_wait_timer, pause_wait_timer_next;
  swd_pkg::phase_t pause_phase, pause_phase_next;

  // Input and result stages.
  logic          in_full;
  swd_pkg::in_t  in_hold;
  logic          advance;
  swd_pkg::out_t result;

  function automatic swd_pkg::deb_t debounce_step(swd_pkg::phase_t phase, logic [7:0] timer,
                                                  logic level, logic [7:0] limit);
    swd_pkg::deb_t r;
    logic [7:0]    t;
    r.phase  = phase;
    r.timer  = timer;
    r.toggle = 1'b0;
    t        = timer + 8'd1;
    case (phase)
      swd_pkg::PH_WAIT: begin
        if (t >= limit) begin
          r.timer = '0;
          if (level) begin
            r.phase  = swd_pkg::PH_RELEASE;
            r.toggle = 1'b1;
          end else begin
            r.phase = swd_pkg::PH_IDLE;
          end
        end else begin
          r.timer = t;
        end
      end
      swd_pkg::PH_RELEASE: begin
        if (!level) begin
          r.phase = swd_pkg::PH_IDLE;
        end
      end
      default: begin
        if (level) begin
          r.phase = swd_pkg::PH_WAIT;
          r.timer = '0;
        end else begin
          r.phase = swd_pkg::PH_IDLE;
        end
      end
    endcase
    return r;
  endfunction

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= swd_pkg::DEBOUNCE_RESET;
      digit_ticks        <= swd_pkg::DIGIT_RESET;
      count_period_ticks <= swd_pkg::COUNT_PERIOD_RESET;
      cathode_polarity   <= 1'b0;
    end else if (cfg_write_en) begin
      case (swd_pkg::cfg_reg_t'(cfg_index))
        swd_pkg::CFG_DEBOUNCE_TICKS:     debounce_ticks     <= cfg_data[7:0];
        swd_pkg::CFG_DIGIT_TICKS:        digit_ticks        <= cfg_data[7:0];
        swd_pkg::CFG_COUNT_PERIOD_TICKS: count_period_ticks <= cfg_data;
        swd_pkg::CFG_CATHODE_POLARITY:   cathode_polarity   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_hold <= in_data;
    end
  end

  always_comb begin
    swd_pkg::deb_t start_deb;
    swd_pkg::deb_t pause_deb;
    logic [7:0]    dt_inc;
    logic [7:0]    seg;
    logic          ten_en;
    logic          unit_en;

    running_next          = running;
    paused_next           = paused;
    tens_digit_next       = tens_digit;
    units_digit_next      = units_digit;
    period_timer_next     = period_timer;
    digit_timer_next      = digit_timer;
    digit_select_next     = digit_select;
    pause_phase_next      = pause_phase;
    pause_wait_timer_next = pause_wait_timer;
    ten_en                = 1'b0;
    unit_en               = 1'b0;

    start_deb = debounce_step(start_phase, start_wait_timer, in_hold.start_button,
                              debounce_ticks);
    start_phase_next      = start_deb.phase;
    start_wait_timer_next = start_deb.timer;

    if (start_deb.toggle) begin
      running_next      = !running;
      period_timer_next = '0;
      digit_timer_next  = '0;
      digit_select_next = 1'b0;
      if (running) begin
        tens_digit_next  = '0;
        units_digit_next = '0;
        paused_next      = 1'b1;
      end
    end

    pause_deb = debounce_step(pause_phase, pause_wait_timer, in_hold.pause_button,
                              debounce_ticks);

    if (running_next) begin
      pause_phase_next      = pause_deb.phase;
      pause_wait_timer_next = pause_deb.timer;
      if (pause_deb.toggle) begin
        paused_next = !paused_next;
      end

      // The period timer keeps running while paused; only the count step is held.
      if ({1'b0, period_timer_next} + 17'd1 >= {1'b0, count_period_ticks}) begin
        period_timer_next = '0;
        if (!paused_next) begin
          if (units_digit_next >= 4'd9) begin
            units_digit_next = '0;
            tens_digit_next  = (tens_digit_next >= 4'd9) ? 4'd0 : tens_digit_next + 4'd1;
          end else begin
            units_digit_next = units_digit_next + 4'd1;
          end
        end
      end else begin
        period_timer_next = period_timer_next + 16'd1;
      end

      if (digit_select_next) begin
        seg     = swd_pkg::seg_code(units_digit_next, cathode_polarity);
        unit_en = 1'b1;
      end else begin
        seg    = swd_pkg::seg_code(tens_digit_next, cathode_polarity);
        ten_en = 1'b1;
      end
      dt_inc = digit_timer_next + 8'd1;
      if (dt_inc >= digit_ticks) begin
        digit_timer_next  = '0;
        digit_select_next = !digit_select_next;
      end else begin
        digit_timer_next = dt_inc;
      end
    end else begin
      pause_phase_next      = swd_pkg::PH_IDLE;
      pause_wait_timer_next = '0;
      period_timer_next     = '0;
      digit_timer_next      = '0;
      digit_select_next     = 1'b0;
      dt_inc                = '0;
      seg = cathode_polarity ? swd_pkg::BLANK_CATHODE : swd_pkg::BLANK_ANODE;
    end

    result.segments     = seg;
    result.tens_enable  = ten_en;
    result.units_enable = unit_en;
    result.green_led_n  = !running_next;
    result.yellow_led_n = !(running_next && paused_next);
    result.count_value  = {tens_digit_next, 3'b000} + {2'b00, tens_digit_next, 1'b0}
                        + {3'b000, units_digit_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running          <= 1'b0;
      paused           <= 1'b1;
      tens_digit       <= '0;
      units_digit      <= '0;
      period_timer     <= '0;
      digit_timer      <= '0;
      digit_select     <= 1'b0;
      start_wait_timer <= '0;
      start_phase      <= swd_pkg::PH_IDLE;
      pause_wait_timer <= '0;
      pause_phase      <= swd_pkg::PH_IDLE;
    end else if (advance) begin
      running          <= running_next;
      paused           <= paused_next;
      tens_digit       <= tens_digit_next;
      units_digit      <= units_digit_next;
      period_timer     <= period_timer_next;
      digit_timer      <= digit_timer_next;
      digit_select     <= digit_select_next;
      start_wait_timer <= start_wait_timer_next;
      start_phase      <= start_phase_next;
      pause_wait_timer <= pause_wait_timer_next;
      pause_phase      <= pause_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  `SWD_ASSERT(a_digits_bcd, clk, rst, (tens_digit <= 4'd9) && (units_digit <= 4'd9))
  `SWD_ASSERT_IMPLY(a_stopped_paused, clk, rst, !running, paused)
  `SWD_ASSERT_IMPLY(a_one_digit, clk, rst, out_valid,
                    $onehot0({out_data.tens_enable, out_data.units_enable}))
  `SWD_ASSERT_IMPLY(a_stopped_blank, clk, rst, out_valid && out_data.green_led_n,
                    !out_data.tens_enable && !out_data.units_enable && out_data.count_value == 7'd0)
  `SWD_ASSERT_IMPLY(a_count_range, clk, rst, out_valid, out_data.count_value <= 7'd99)

endmodule
